// File: sv/mbps_pkg.sv
package mbps_pkg;

  localparam int AddrW   = 32;
  localparam int CntW    = 33;
  localparam int LimW    = 34;
  localparam int LenW    = 7;
  localparam int PlenW   = 6;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 64;
  localparam int PatBytes = 32;

  localparam logic [CfgIdxW-1:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCAN_LENGTH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CARE_MASK      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD_0 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD_1 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD_2 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PATTERN_WORD_3 = 3'd7;

  localparam logic [PlenW-1:0]   PLEN_RESET = 6'd32;

  // settings derived from the config registers, consumed by the scan stage
  typedef struct packed {
    logic [LimW-1:0]  limit;     // scan_length + effective length
    logic [AddrW-1:0] addr_off;  // base_address - effective length
    logic [LenW-1:0]  len;       // effective pattern length
  } scan_cfg_t;

endpackage

// File: sv/mbps_cfg.sv
module mbps_cfg #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mbps_pkg::CfgDatW-1:0]    cfg_data,
  output mbps_pkg::scan_cfg_t             scan_cfg,
  output logic [PATTERN_MAX-1:0]          need_care,
  output logic [PATTERN_MAX-1:0][7:0]     need_byte
);
  import mbps_pkg::*;

  logic [AddrW-1:0]        base_r;
  logic [AddrW-1:0]        scan_len_r;
  logic [PlenW-1:0]        pat_len_r;
  logic [PatBytes-1:0]     care_r;
  logic [3:0][CfgDatW-1:0] pat_r;

  logic [PatBytes-1:0][7:0] pat_bytes;
  logic [LenW-1:0]          eff_len;
  scan_cfg_t                scan_cfg_nxt;
  logic [PATTERN_MAX-1:0]   care_nxt;
  logic [PATTERN_MAX-1:0][7:0] byte_nxt;

  scan_cfg_t                   scan_cfg_r;
  logic [PATTERN_MAX-1:0]      care_al_r;
  logic [PATTERN_MAX-1:0][7:0] byte_al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      scan_len_r <= '0;
      pat_len_r  <= PLEN_RESET;
      care_r     <= '1;
      pat_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_ADDRESS:   base_r     <= cfg_data[AddrW-1:0];
        REG_SCAN_LENGTH:    scan_len_r <= cfg_data[AddrW-1:0];
        REG_PATTERN_LENGTH: pat_len_r  <= cfg_data[PlenW-1:0];
        REG_CARE_MASK:      care_r     <= cfg_data[PatBytes-1:0];
        REG_PATTERN_WORD_0: pat_r[0]   <= cfg_data;
        REG_PATTERN_WORD_1: pat_r[1]   <= cfg_data;
        REG_PATTERN_WORD_2: pat_r[2]   <= cfg_data;
        REG_PATTERN_WORD_3: pat_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_r;

  always_comb begin
    eff_len = {1'b0, pat_len_r};
    if (pat_len_r == '0) begin
      eff_len = LenW'(1);
    end else if (eff_len > LenW'(PATTERN_MAX)) begin
      eff_len = LenW'(PATTERN_MAX);
    end
  end

  // Window slot i (age i, newest at 0) lines up with pattern byte len-1-i.
  always_comb begin
    logic [LenW-1:0] j;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      j           = eff_len - LenW'(1) - LenW'(i);
      care_nxt[i] = 1'b0;
      byte_nxt[i] = pat_bytes[j[4:0]];
      if (LenW'(i) < eff_len && j < LenW'(PatBytes)) begin
        care_nxt[i] = care_r[j[4:0]];
      end
    end
  end

  assign scan_cfg_nxt.limit    = {2'b00, scan_len_r} + LimW'(eff_len);
  assign scan_cfg_nxt.addr_off = base_r - AddrW'(eff_len);
  assign scan_cfg_nxt.len      = eff_len;

  always_ff @(posedge clk) begin
    scan_cfg_r <= scan_cfg_nxt;
    care_al_r  <= care_nxt;
    byte_al_r  <= byte_nxt;
  end

  assign scan_cfg  = scan_cfg_r;
  assign need_care = care_al_r;
  assign need_byte = byte_al_r;

endmodule

// File: sv/mbps_core.sv
module mbps_core #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mbps_pkg::scan_cfg_t             scan_cfg,
  input  logic [PATTERN_MAX-1:0]          need_care,
  input  logic [PATTERN_MAX-1:0][7:0]     need_byte,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte_value,
  input  logic                            in_end_of_stream,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [mbps_pkg::AddrW-1:0]      out_match_address
);
  import mbps_pkg::*;

  logic                        in_v_r;
  logic [7:0]                  in_byte_r;
  logic                        in_last_r;

  logic [PATTERN_MAX-1:0][7:0] win_r;
  logic [PATTERN_MAX-1:0][7:0] win_nxt;
  logic [CntW-1:0]             cnt_r;
  logic [CntW-1:0]             cnt_inc;
  logic                        reported_r;

  logic                        out_v_r;
  logic                        out_found_r;
  logic [AddrW-1:0]            out_addr_r;

  logic                        adv;
  logic                        all_ok;
  logic                        hit;
  logic                        emit;
  logic [AddrW-1:0]            hit_addr;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte_value;
      in_last_r <= in_end_of_stream;
    end
  end

  assign win_nxt = {win_r[PATTERN_MAX-2:0], in_byte_r};
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + CntW'(1);

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (need_care[i] && win_nxt[i] != need_byte[i]) begin
        all_ok = 1'b0;
      end
    end
  end

  // start = cnt - len must be below scan_length: cnt < scan_length + len
  assign hit = !reported_r && all_ok
            && cnt_inc >= CntW'(scan_cfg.len)
            && {1'b0, cnt_inc} < scan_cfg.limit;
  assign emit     = hit || (!reported_r && in_last_r);
  assign hit_addr = scan_cfg.addr_off + cnt_inc[AddrW-1:0];

  // window bytes older than the count are never compared, so it needs no clear
  always_ff @(posedge clk) begin
    if (adv && !reported_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      reported_r <= 1'b0;
    end else if (adv) begin
      if (in_last_r) begin
        cnt_r      <= '0;
        reported_r <= 1'b0;
      end else if (!reported_r) begin
        cnt_r      <= cnt_inc;
        reported_r <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= (out_v_r && !out_ready) || (adv && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? hit_addr : '0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

// File: sv/masked_byte_pattern_scan.sv
// Searches a byte stream for the first start offset where a masked pattern of up to
// 32 bytes matches, and returns one result per stream: found with base_address plus
// offset, or not found when the byte flagged end_of_stream arrives without a match.
// Bytes after a match are swallowed up to end of stream. One byte is taken every
// cycle unless a pending result is held by out_ready; each byte passes an input
// register and then a result register. All window compares are done in parallel
// in the single stage between them. Program the registers only while the block is
// idle; the derived alignment settings are registered and follow a write next cycle.
module masked_byte_pattern_scan #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mbps_pkg::CfgDatW-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte_value,
  input  logic                            in_end_of_stream,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [mbps_pkg::AddrW-1:0]      out_match_address
);
  import mbps_pkg::*;

  scan_cfg_t                   scan_cfg;
  logic [PATTERN_MAX-1:0]      need_care;
  logic [PATTERN_MAX-1:0][7:0] need_byte;

  mbps_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan_cfg  (scan_cfg),
    .need_care (need_care),
    .need_byte (need_byte)
  );

  mbps_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .scan_cfg          (scan_cfg),
    .need_care         (need_care),
    .need_byte         (need_byte),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

endmodule
